// ===== design/ffra_pkg.sv =====
// Shared types and constants for the first-fit region allocator.
// Field widths, status and operation codes, config register indexes.
// No dependencies; compile first.
package ffra_pkg;

  // Field widths
  localparam int ADDR_W     = 20;
  localparam int FUNC_W     = 1;
  localparam int ID_W       = 5;
  localparam int SIZE_W     = 16;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = ADDR_W + 1;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_ALLOC = 1'b0;
  localparam logic [FUNC_W-1:0] FN_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'b1;

  // Highest usable exclusive end address
  localparam logic [ADDR_W:0] CAP_MAX = {1'b1, {ADDR_W{1'b0}}};

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_BAD_ID       = 3'd1,
    ST_NO_SPACE     = 3'd2,
    ST_ALREADY_FREE = 3'd3,
    ST_LIST_FULL    = 3'd4
  } status_t;

  // One address range: start and exclusive end
  typedef struct packed {
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W:0]   hi;
  } span_t;

endpackage

// ===== design/ffra_if.sv =====
// Handshake channels of the region allocator: request and result.
// Depends on ffra_pkg for field widths.
interface ffra_req_if;
  logic                          valid;
  logic                          ready;
  logic [ffra_pkg::FUNC_W-1:0]   func;
  logic [ffra_pkg::ID_W-1:0]     region_id;
  logic [ffra_pkg::SIZE_W-1:0]   req_size;

  modport source (output valid, func, region_id, req_size, input ready);
  modport sink   (input valid, func, region_id, req_size, output ready);
endinterface

interface ffra_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ffra_pkg::STATUS_W-1:0] status;
  logic [ffra_pkg::ADDR_W-1:0]   region_start;
  logic [ffra_pkg::ADDR_W:0]     region_end;

  modport source (output valid, status, region_start, region_end, input ready);
  modport sink   (input valid, status, region_start, region_end, output ready);
endinterface

// ===== design/first_fit_region_allocator_core.sv =====
// Allocate scans the free list from the head (entry 0) for the first range that
// fits and carves from its start, closing the gap when it is used whole; with no
// fit it grows the break by whole pages and pushes any unused rest at the head.
// Free shifts the list up, tail first, and pushes the range at the head. A bad id
// or zero-size allocate is refused at accept. Ready only when idle: one at a time.
// Reset (synchronous, rst_n low): empty list, table all free, break 0, no limit.
module first_fit_region_allocator_core #(
  parameter int FREE_SLOTS = 16,
  parameter int SYMBOLS    = 32,
  parameter int PAGE_SIZE  = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ffra_req_if.sink                         in_req,
  ffra_rsp_if.source                       out_rsp,
  input  logic                             cfg_we,
  input  logic [ffra_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [ffra_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int ADDR_W  = ffra_pkg::ADDR_W;
  localparam int SIZE_W  = ffra_pkg::SIZE_W;
  localparam int FS_AW   = $clog2(FREE_SLOTS);
  localparam int CNT_W   = $clog2(FREE_SLOTS + 1);
  localparam int SYM_AW  = $clog2(SYMBOLS);
  // Rounding arithmetic: x = size + page - 1 fits in X_W bits
  localparam int X_W     = SIZE_W + 1;
  localparam int INC_W   = X_W + 1;
  localparam int RECIP_W = X_W + 1;
  localparam int PROD_W  = X_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((1 << X_W) / PAGE_SIZE);
  localparam logic [INC_W-1:0]   PAGE_V  = INC_W'(PAGE_SIZE);
  localparam logic [X_W-1:0]     PAGE_M1 = X_W'(PAGE_SIZE - 1);
  localparam logic [CNT_W-1:0]   CNT_FULL = CNT_W'(FREE_SLOTS);

  // Sequencer states
  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_SCAN_CMP  = 14'b00000000000010,
    S_CARVE     = 14'b00000000000100,
    S_PULL      = 14'b00000000001000,
    S_GROW_MUL  = 14'b00000000010000,
    S_GROW_QP   = 14'b00000000100000,
    S_GROW_FIX  = 14'b00000001000000,
    S_GROW_CHK  = 14'b00000010000000,
    S_FREE_CHK  = 14'b00000100000000,
    S_PUSH_RD   = 14'b00001000000000,
    S_PUSH_MV   = 14'b00010000000000,
    S_PUSH_HEAD = 14'b00100000000000,
    S_RESP      = 14'b01000000000000,
    S_SPARE     = 14'b10000000000000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [FS_AW-1:0]           idx_r, idx_nxt;
  logic [ADDR_W:0]            brk_r, brk_nxt;
  logic [ADDR_W:0]            cap_r, cap_nxt;
  logic [SYMBOLS-1:0]         sym_vld_r, sym_vld_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic [ffra_pkg::ID_W-1:0]  id_r, id_nxt;
  logic [SIZE_W-1:0]          size_r, size_nxt;
  ffra_pkg::span_t            hit_r, hit_nxt;
  ffra_pkg::span_t            ins_r, ins_nxt;
  logic [PROD_W-1:0]          prod_r, prod_nxt;
  logic [INC_W-1:0]           qp_r, qp_nxt;
  logic [INC_W-1:0]           inc_r, inc_nxt;
  ffra_pkg::status_t          res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]          res_lo_r, res_lo_nxt;
  logic [ADDR_W:0]            res_hi_r, res_hi_nxt;
  ffra_pkg::status_t          out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]          out_lo_r, out_lo_nxt;
  logic [ADDR_W:0]            out_hi_r, out_hi_nxt;

  // Free-list memory: head at entry 0
  ffra_pkg::span_t            fl_mem [FREE_SLOTS];
  ffra_pkg::span_t            fl_rd_r;
  logic [FS_AW-1:0]           fl_raddr, fl_waddr;
  logic                       fl_we;
  ffra_pkg::span_t            fl_wdata;

  // Per-id range table; a clear valid bit reads as a free id
  ffra_pkg::span_t            sym_mem [SYMBOLS];
  ffra_pkg::span_t            sym_rd_r;
  logic [SYM_AW-1:0]          sym_raddr;
  logic                       sym_we;
  ffra_pkg::span_t            sym_wdata;

  // Datapath terms
  logic [X_W-1:0]             x_sz;
  logic [X_W-1:0]             q_est;
  logic [INC_W-1:0]           rem;
  logic [INC_W-1:0]           inc_fix;
  logic [ADDR_W+1:0]          brk_new;
  logic [ADDR_W+1:0]          grow_end;
  logic [ADDR_W:0]            scan_sum;
  logic                       fit;
  logic [ADDR_W:0]            carve_end;
  logic [CNT_W-1:0]           idx_p1, idx_p2;
  logic [FS_AW-1:0]           last_idx;
  logic [SYM_AW-1:0]          id_addr;

  assign x_sz      = X_W'(size_r) + PAGE_M1;
  assign q_est     = X_W'(prod_r >> X_W);
  assign rem       = INC_W'(x_sz) - qp_r;
  // Reciprocal estimate is at most one page short: add it back if so
  assign inc_fix   = (rem >= PAGE_V) ? qp_r + PAGE_V : qp_r;
  assign brk_new   = (ADDR_W + 2)'(brk_r) + (ADDR_W + 2)'(inc_r);
  assign grow_end  = (ADDR_W + 2)'(brk_r) + (ADDR_W + 2)'(size_r);
  assign scan_sum  = (ADDR_W + 1)'(fl_rd_r.lo) + (ADDR_W + 1)'(size_r);
  assign fit       = (scan_sum <= fl_rd_r.hi);
  assign carve_end = (ADDR_W + 1)'(hit_r.lo) + (ADDR_W + 1)'(size_r);
  assign idx_p1    = CNT_W'(idx_r) + CNT_W'(1);
  assign idx_p2    = idx_p1 + CNT_W'(1);
  assign last_idx  = FS_AW'(count_r - CNT_W'(1));
  assign id_addr   = SYM_AW'(id_r);

  assign in_req.ready         = (state_r == S_IDLE);
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.region_start = out_lo_r;
  assign out_rsp.region_end   = out_hi_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    brk_nxt        = brk_r;
    cap_nxt        = cap_r;
    sym_vld_nxt    = sym_vld_r;
    id_nxt         = id_r;
    size_nxt       = size_r;
    hit_nxt        = hit_r;
    ins_nxt        = ins_r;
    prod_nxt       = prod_r;
    qp_nxt         = qp_r;
    inc_nxt        = inc_r;
    res_status_nxt = res_status_r;
    res_lo_nxt     = res_lo_r;
    res_hi_nxt     = res_hi_r;
    out_status_nxt = out_status_r;
    out_lo_nxt     = out_lo_r;
    out_hi_nxt     = out_hi_r;
    // Drop the result once the sink takes it
    out_valid_nxt  = out_valid_r && !out_rsp.ready;

    fl_raddr       = '0;
    fl_we          = 1'b0;
    fl_waddr       = idx_r;
    fl_wdata       = fl_rd_r;
    sym_raddr      = id_addr;
    sym_we         = 1'b0;
    sym_wdata      = '{lo: hit_r.lo, hi: carve_end};

    // Configuration writes are for the user to make only while idle; the block does not enforce it
    if (cfg_we) begin
      case (cfg_idx)
        ffra_pkg::CFG_HEAP_BASE: begin
          brk_nxt = {1'b0, cfg_wdata[ADDR_W-1:0]};
        end
        ffra_pkg::CFG_HEAP_LIMIT: begin
          cap_nxt = (cfg_wdata > ffra_pkg::CAP_MAX) ? ffra_pkg::CAP_MAX : cfg_wdata;
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      S_IDLE: begin
        // Read the table and the list head ahead of the decision
        sym_raddr = SYM_AW'(in_req.region_id);
        if (in_req.valid) begin
          id_nxt   = in_req.region_id;
          size_nxt = in_req.req_size;
          idx_nxt  = '0;
          if (32'(in_req.region_id) >= SYMBOLS) begin
            res_status_nxt = ffra_pkg::ST_BAD_ID;
            res_lo_nxt     = '0;
            res_hi_nxt     = '0;
            state_nxt      = S_RESP;
          end else if (in_req.func == ffra_pkg::FN_FREE) begin
            state_nxt = S_FREE_CHK;
          end else if (in_req.req_size == '0) begin
            res_status_nxt = ffra_pkg::ST_NO_SPACE;
            res_lo_nxt     = '0;
            res_hi_nxt     = '0;
            state_nxt      = S_RESP;
          end else if (count_r == '0) begin
            state_nxt = S_GROW_MUL;
          end else begin
            state_nxt = S_SCAN_CMP;
          end
        end
      end

      S_SCAN_CMP: begin
        // Compare entry idx while fetching the next one
        fl_raddr = FS_AW'(idx_p1);
        if (fit) begin
          hit_nxt   = fl_rd_r;
          state_nxt = S_CARVE;
        end else if (idx_p1 == count_r) begin
          state_nxt = S_GROW_MUL;
        end else begin
          idx_nxt = FS_AW'(idx_p1);
        end
      end

      S_CARVE: begin
        res_status_nxt   = ffra_pkg::ST_OK;
        res_lo_nxt       = hit_r.lo;
        res_hi_nxt       = carve_end;
        sym_we           = 1'b1;
        sym_vld_nxt[id_addr] = 1'b1;
        if (carve_end == hit_r.hi) begin
          // Exact fit: close the gap
          if (idx_p1 == count_r) begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_RESP;
          end else begin
            fl_raddr  = FS_AW'(idx_p1);
            state_nxt = S_PULL;
          end
        end else begin
          fl_we     = 1'b1;
          fl_waddr  = idx_r;
          fl_wdata  = '{lo: carve_end[ADDR_W-1:0], hi: hit_r.hi};
          state_nxt = S_RESP;
        end
      end

      S_PULL: begin
        // Move entry idx+1 down to idx
        fl_we    = 1'b1;
        fl_waddr = idx_r;
        fl_wdata = fl_rd_r;
        if (idx_p2 == count_r) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_RESP;
        end else begin
          fl_raddr = FS_AW'(idx_p2);
          idx_nxt  = FS_AW'(idx_p1);
        end
      end

      S_GROW_MUL: begin
        prod_nxt  = x_sz * RECIP;
        state_nxt = S_GROW_QP;
      end

      S_GROW_QP: begin
        qp_nxt    = INC_W'(q_est) * PAGE_V;
        state_nxt = S_GROW_FIX;
      end

      S_GROW_FIX: begin
        inc_nxt   = inc_fix;
        state_nxt = S_GROW_CHK;
      end

      S_GROW_CHK: begin
        if (count_r == CNT_FULL) begin
          res_status_nxt = ffra_pkg::ST_LIST_FULL;
          res_lo_nxt     = '0;
          res_hi_nxt     = '0;
          state_nxt      = S_RESP;
        end else if (brk_new > (ADDR_W + 2)'(cap_r)) begin
          res_status_nxt = ffra_pkg::ST_NO_SPACE;
          res_lo_nxt     = '0;
          res_hi_nxt     = '0;
          state_nxt      = S_RESP;
        end else begin
          res_status_nxt = ffra_pkg::ST_OK;
          res_lo_nxt     = brk_r[ADDR_W-1:0];
          res_hi_nxt     = grow_end[ADDR_W:0];
          sym_we         = 1'b1;
          sym_wdata      = '{lo: brk_r[ADDR_W-1:0], hi: grow_end[ADDR_W:0]};
          sym_vld_nxt[id_addr] = 1'b1;
          brk_nxt        = brk_new[ADDR_W:0];
          if (grow_end == brk_new) begin
            // Whole new range used: the list is left as it was
            state_nxt = S_RESP;
          end else begin
            ins_nxt = '{lo: grow_end[ADDR_W-1:0], hi: brk_new[ADDR_W:0]};
            if (count_r == '0) begin
              state_nxt = S_PUSH_HEAD;
            end else begin
              idx_nxt   = last_idx;
              state_nxt = S_PUSH_RD;
            end
          end
        end
      end

      S_FREE_CHK: begin
        if (!sym_vld_r[id_addr]) begin
          res_status_nxt = ffra_pkg::ST_ALREADY_FREE;
          res_lo_nxt     = '0;
          res_hi_nxt     = '0;
          state_nxt      = S_RESP;
        end else if (count_r == CNT_FULL) begin
          res_status_nxt = ffra_pkg::ST_LIST_FULL;
          res_lo_nxt     = '0;
          res_hi_nxt     = '0;
          state_nxt      = S_RESP;
        end else begin
          sym_vld_nxt[id_addr] = 1'b0;
          res_status_nxt = ffra_pkg::ST_OK;
          res_lo_nxt     = sym_rd_r.lo;
          res_hi_nxt     = sym_rd_r.hi;
          ins_nxt        = sym_rd_r;
          if (count_r == '0) begin
            state_nxt = S_PUSH_HEAD;
          end else begin
            idx_nxt   = last_idx;
            state_nxt = S_PUSH_RD;
          end
        end
      end

      S_PUSH_RD: begin
        fl_raddr  = idx_r;
        state_nxt = S_PUSH_MV;
      end

      S_PUSH_MV: begin
        // Shift entry idx up one place, tail first
        fl_we    = 1'b1;
        fl_waddr = FS_AW'(idx_p1);
        fl_wdata = fl_rd_r;
        fl_raddr = idx_r - FS_AW'(1);
        if (idx_r == '0) begin
          state_nxt = S_PUSH_HEAD;
        end else begin
          idx_nxt = idx_r - FS_AW'(1);
        end
      end

      S_PUSH_HEAD: begin
        fl_we     = 1'b1;
        fl_waddr  = '0;
        fl_wdata  = ins_r;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_lo_nxt     = res_lo_r;
          out_hi_nxt     = res_hi_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      brk_r       <= '0;
      cap_r       <= ffra_pkg::CAP_MAX;
      sym_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      brk_r       <= brk_nxt;
      cap_r       <= cap_nxt;
      sym_vld_r   <= sym_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    id_r         <= id_nxt;
    size_r       <= size_nxt;
    hit_r        <= hit_nxt;
    ins_r        <= ins_nxt;
    prod_r       <= prod_nxt;
    qp_r         <= qp_nxt;
    inc_r        <= inc_nxt;
    res_status_r <= res_status_nxt;
    res_lo_r     <= res_lo_nxt;
    res_hi_r     <= res_hi_nxt;
    out_status_r <= out_status_nxt;
    out_lo_r     <= out_lo_nxt;
    out_hi_r     <= out_hi_nxt;
  end

  // Free-list memory: one write, one registered read a cycle
  always_ff @(posedge clk) begin
    if (fl_we) begin
      fl_mem[fl_waddr] <= fl_wdata;
    end
    fl_rd_r <= fl_mem[fl_raddr];
  end

  // Range table memory
  always_ff @(posedge clk) begin
    if (sym_we) begin
      sym_mem[id_addr] <= sym_wdata;
    end
    sym_rd_r <= sym_mem[sym_raddr];
  end

endmodule

// ===== design/ffra_checker.sv =====
// Port-level checks for first_fit_region_allocator_core, and the bind
// that attaches them. Depends on ffra_pkg for status codes.
module ffra_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [ffra_pkg::STATUS_W-1:0]    out_status,
  input logic [ffra_pkg::ADDR_W-1:0]      out_start,
  input logic [ffra_pkg::ADDR_W:0]        out_end
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_start) && $stable(out_end))
    else $error("result changed while stalled");

  // Error results carry no range
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ffra_pkg::ST_OK |-> out_start == '0 && out_end == '0)
    else $error("error result with non-zero range");

  // A good result is a non-empty range
  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ffra_pkg::ST_OK |-> {1'b0, out_start} < out_end)
    else $error("empty or inverted range on success");

  // One item at a time: ready drops after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

endmodule

bind first_fit_region_allocator_core ffra_checker u_ffra_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .out_status (out_rsp.status),
  .out_start  (out_rsp.region_start),
  .out_end    (out_rsp.region_end)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for first_fit_region_allocator_core: directed then random alloc/free
// items, each result checked against a behavioural allocator kept in step with the block.
// Depends on ffra_pkg, the channel interfaces in ffra_if.sv and the core RTL.
module tb_top;

  localparam int          FREE_SLOTS  = 16;
  localparam int          SYMBOLS     = 32;
  localparam int          PAGE_SIZE   = 256;
  localparam int unsigned ADDR_SPAN   = 32'd1 << ffra_pkg::ADDR_W;
  localparam int          MAX_REPORTS = 10;
  localparam int          HOLD_CYCLES = 300;
  localparam int          TAIL_CYCLES = 40;

  // Size mixes for the random part
  localparam int MIX_GENERAL = 0;
  localparam int MIX_CRUMBS  = 1;

  typedef struct packed {
    logic [ffra_pkg::FUNC_W-1:0] func;
    logic [ffra_pkg::ID_W-1:0]   region_id;
    logic [ffra_pkg::SIZE_W-1:0] nbytes;
  } request_t;

  typedef struct packed {
    ffra_pkg::status_t status;
    ffra_pkg::span_t   span;
  } grant_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [ffra_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [ffra_pkg::CFG_DATA_W-1:0] cfg_wdata;

  ffra_req_if req_ch ();
  ffra_rsp_if rsp_ch ();

  first_fit_region_allocator_core #(
    .FREE_SLOTS (FREE_SLOTS),
    .SYMBOLS    (SYMBOLS),
    .PAGE_SIZE  (PAGE_SIZE)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_rsp   (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Shadow allocator: free ranges in list order (head first), per-id ranges,
  // the break and the two registers. Kept in step with every accepted item.
  // ---------------------------------------------------------------------------
  int unsigned hole_lo[$];
  int unsigned hole_hi[$];
  int unsigned owner_lo[SYMBOLS];
  int unsigned owner_hi[SYMBOLS];
  int unsigned brk       = 0;
  int unsigned base_addr = 0;
  int unsigned top_limit = ADDR_SPAN;

  // Results owed by the block, oldest first
  grant_t grants_due[$];

  // Items waiting for the driver, and the one currently offered
  request_t backlog[$];
  request_t on_offer;
  bit       offering = 1'b0;

  int   taken  = 0;
  int   faults = 0;
  logic steady;
  logic hold_rsp;

  // Bookkeeping for the stimulus generator only: which ids it believes are live
  bit          gen_live[SYMBOLS];
  int unsigned gen_len[SYMBOLS];
  int unsigned freed_sizes[$];

  // Work out the result of one item and apply its effect on the shadow state.
  function automatic grant_t allot(request_t rq);
    grant_t      g;
    int unsigned sz, inc, cap, lo, hi;
    int          hit;
    g.status = ffra_pkg::ST_OK;
    g.span   = '0;
    sz       = 32'(rq.nbytes);
    if (rq.region_id >= SYMBOLS) begin
      g.status = ffra_pkg::ST_BAD_ID;
      return g;
    end
    if (rq.func == ffra_pkg::FN_ALLOC) begin
      if (sz == 0) begin
        g.status = ffra_pkg::ST_NO_SPACE;
        return g;
      end
      // First fit: the earliest range in list order with room
      hit = -1;
      foreach (hole_lo[k]) begin
        if (hit < 0 && hole_lo[k] + sz <= hole_hi[k]) hit = k;
      end
      if (hit < 0) begin
        // Nothing fits: grow the break by whole pages, unless the list is full
        // or the grown break would pass the capped limit
        inc = (sz + PAGE_SIZE - 1) / PAGE_SIZE * PAGE_SIZE;
        cap = (top_limit < ADDR_SPAN) ? top_limit : ADDR_SPAN;
        if (hole_lo.size() >= FREE_SLOTS) begin
          g.status = ffra_pkg::ST_LIST_FULL;
          return g;
        end
        if (brk + inc > cap) begin
          g.status = ffra_pkg::ST_NO_SPACE;
          return g;
        end
        hole_lo.push_front(brk);
        hole_hi.push_front(brk + inc);
        brk += inc;
        hit = 0;
      end
      lo = hole_lo[hit];
      hi = lo + sz;
      // An exact fit leaves the list; otherwise carve from the start
      if (hi == hole_hi[hit]) begin
        hole_lo.delete(hit);
        hole_hi.delete(hit);
      end else begin
        hole_lo[hit] = hi;
      end
      // A live id is simply overwritten; its old range is lost
      owner_lo[rq.region_id] = lo;
      owner_hi[rq.region_id] = hi;
    end else begin
      lo = owner_lo[rq.region_id];
      hi = owner_hi[rq.region_id];
      if (lo >= hi) begin
        g.status = ffra_pkg::ST_ALREADY_FREE;
        return g;
      end
      if (hole_lo.size() >= FREE_SLOTS) begin
        g.status = ffra_pkg::ST_LIST_FULL;
        return g;
      end
      hole_lo.push_front(lo);
      hole_hi.push_front(hi);
      owner_lo[rq.region_id] = 0;
      owner_hi[rq.region_id] = 0;
    end
    g.span.lo = lo[ffra_pkg::ADDR_W-1:0];
    g.span.hi = hi[ffra_pkg::ADDR_W:0];
    return g;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and time limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Time limit, far beyond what the whole run needs
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Request driver: change inputs on the falling edge, note acceptance on the
  // rising edge. Valid stays up from one item to the next when there is no gap.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && req_ch.valid && req_ch.ready) begin
      grants_due.push_back(allot(on_offer));
      offering = 1'b0;
      taken++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (!offering) begin
      if (backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 24)) begin
        on_offer = backlog.pop_front();
        offering = 1'b1;
        req_ch.valid     <= 1'b1;
        req_ch.func      <= on_offer.func;
        req_ch.region_id <= on_offer.region_id;
        req_ch.req_size  <= on_offer.nbytes;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: stall at random, hold off completely while hold_rsp is up,
  // and check each accepted result against the oldest owed one.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= !hold_rsp && (steady || $urandom_range(0, 99) >= 24);
    end
  end

  task automatic log_fault(string field, logic [31:0] want, logic [31:0] got);
    faults++;
    if (faults <= MAX_REPORTS) begin
      $display("mismatch %0d at %0t: %s expected 0x%0h got 0x%0h",
               faults, $realtime, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (grants_due.size() == 0) begin
        log_fault("result with nothing owed, status", '0, 32'(rsp_ch.status));
      end else begin
        want = grants_due.pop_front();
        if (rsp_ch.status !== want.status)
          log_fault("status", 32'(want.status), 32'(rsp_ch.status));
        if (rsp_ch.region_start !== want.span.lo)
          log_fault("region_start", 32'(want.span.lo), 32'(rsp_ch.region_start));
        if (rsp_ch.region_end !== want.span.hi)
          log_fault("region_end", 32'(want.span.hi), 32'(rsp_ch.region_end));
      end
    end
  end

  // Back-pressure: once well into the run, refuse results for a long stretch so
  // that the block holds its result and stops taking items.
  initial begin
    hold_rsp = 1'b0;
    wait (taken >= 200);
    @(negedge clk);
    hold_rsp <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_rsp <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Queue one item and track what the generator believes about the ids
  task automatic queue_req(logic [ffra_pkg::FUNC_W-1:0] fn, int id, int unsigned sz);
    request_t rq;
    rq.func      = fn;
    rq.region_id = id[ffra_pkg::ID_W-1:0];
    rq.nbytes    = sz[ffra_pkg::SIZE_W-1:0];
    if (fn == ffra_pkg::FN_ALLOC) begin
      if (rq.nbytes != 0) begin
        gen_live[rq.region_id] = 1'b1;
        gen_len[rq.region_id]  = 32'(rq.nbytes);
      end
    end else if (gen_live[rq.region_id]) begin
      gen_live[rq.region_id] = 1'b0;
      freed_sizes.push_back(gen_len[rq.region_id]);
      if (freed_sizes.size() > 16) void'(freed_sizes.pop_front());
    end
    backlog.push_back(rq);
  endtask

  // Mostly small sizes; reuse of freed sizes gives exact fits
  function automatic int unsigned draw_size(int mix);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 0;
    if (r < 22 && freed_sizes.size() != 0)
      return freed_sizes[$urandom_range(0, freed_sizes.size() - 1)];
    if (mix == MIX_CRUMBS || r < 60) return $urandom_range(1, 96);
    if (r < 75) return PAGE_SIZE * $urandom_range(1, 16);
    if (r < 92) return $urandom_range(97, 8192);
    return $urandom_range(8193, 65535);
  endfunction

  // Wait until every queued item is taken and every owed result has come,
  // then wait on so that the block can go idle
  task automatic settle();
    do @(negedge clk); while (backlog.size() != 0 || offering || grants_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Register writes, only ever made while the block is idle
  task automatic write_reg(logic [ffra_pkg::CFG_IDX_W-1:0]  idx,
                           logic [ffra_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    if (idx == ffra_pkg::CFG_HEAP_BASE) begin
      base_addr = 32'(val[ffra_pkg::ADDR_W-1:0]);
      brk       = base_addr;
    end else begin
      top_limit = 32'(val);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup(logic [ffra_pkg::CFG_DATA_W-1:0] base,
                       logic [ffra_pkg::CFG_DATA_W-1:0] limit);
    write_reg(ffra_pkg::CFG_HEAP_BASE, base);
    write_reg(ffra_pkg::CFG_HEAP_LIMIT, limit);
  endtask

  // A burst of random items: mostly frees of live ids and allocs on dead ones,
  // some frees of dead ids, allocs over live ids and fully random noise
  task automatic feed(int n, int mix);
    int roll;
    int live_ids[$];
    int dead_ids[$];
    @(posedge clk);
    repeat (n) begin
      live_ids.delete();
      dead_ids.delete();
      foreach (gen_live[k]) begin
        if (gen_live[k]) live_ids.push_back(k);
        else dead_ids.push_back(k);
      end
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        queue_req((ffra_pkg::FUNC_W)'($urandom_range(0, 1)), $urandom_range(0, SYMBOLS - 1),
                  $urandom_range(0, 65535));
      end else if (roll < 10) begin
        queue_req(ffra_pkg::FN_FREE, $urandom_range(0, SYMBOLS - 1), $urandom);
      end else if (roll < 50 && live_ids.size() != 0) begin
        queue_req(ffra_pkg::FN_FREE, live_ids[$urandom_range(0, live_ids.size() - 1)],
                  $urandom);
      end else if (dead_ids.size() != 0 && $urandom_range(0, 99) < 85) begin
        queue_req(ffra_pkg::FN_ALLOC, dead_ids[$urandom_range(0, dead_ids.size() - 1)],
                  draw_size(mix));
      end else begin
        queue_req(ffra_pkg::FN_ALLOC, $urandom_range(0, SYMBOLS - 1), draw_size(mix));
      end
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = '0;
    cfg_wdata           = '0;
    steady              = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.func         = '0;
    req_ch.region_id    = '0;
    req_ch.req_size     = '0;
    rsp_ch.ready        = 1'b0;
    foreach (owner_lo[k]) begin
      owner_lo[k] = 0;
      owner_hi[k] = 0;
      gen_live[k] = 1'b0;
      gen_len[k]  = 0;
    end

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset configuration: base 0, no limit below the address space
    queue_req(ffra_pkg::FN_FREE,  7, 0);        // free of an id that was never allocated
    queue_req(ffra_pkg::FN_ALLOC, 0, 0);        // zero-byte allocate
    queue_req(ffra_pkg::FN_ALLOC, 0, 1);        // empty list: grow by one page, split
    queue_req(ffra_pkg::FN_ALLOC, 1, 255);      // exact fit of the remainder, entry removed
    queue_req(ffra_pkg::FN_ALLOC, 31, 65535);   // largest size, grow by 256 pages
    queue_req(ffra_pkg::FN_ALLOC, 2, 1);        // exact fit of the single byte left over
    queue_req(ffra_pkg::FN_ALLOC, 3, 256);      // grow by exactly one page, taken whole
    queue_req(ffra_pkg::FN_FREE,  0, 16'hFFFF);
    queue_req(ffra_pkg::FN_FREE,  0, 0);        // double free
    queue_req(ffra_pkg::FN_FREE,  31, 0);
    queue_req(ffra_pkg::FN_ALLOC, 4, 100);      // first fit in a freed range
    queue_req(ffra_pkg::FN_ALLOC, 5, 1);
    queue_req(ffra_pkg::FN_ALLOC, 5, 2);        // allocate over a live id
    queue_req(ffra_pkg::FN_FREE,  5, 0);
    queue_req(ffra_pkg::FN_FREE,  1, 0);
    queue_req(ffra_pkg::FN_FREE,  2, 0);
    queue_req(ffra_pkg::FN_FREE,  3, 0);
    queue_req(ffra_pkg::FN_FREE,  4, 0);
    settle();

    // Break at the top of the space; bit 20 of the base write is dropped and a
    // limit above the address space is capped
    setup(21'h1FFFFF, 21'h1FFFFF);
    @(posedge clk);
    queue_req(ffra_pkg::FN_ALLOC, 6, 65535);    // no fit and no room to grow
    queue_req(ffra_pkg::FN_ALLOC, 7, 1);
    settle();
    feed(50, MIX_GENERAL);

    // Reset values written back; pause mid-way until all results are in
    setup(21'd0, 21'h100000);
    feed(60, MIX_GENERAL);
    feed(60, MIX_GENERAL);

    // Unaligned base with between 4 and 96 pages of headroom
    setup((ffra_pkg::CFG_DATA_W)'($urandom_range(20'h40000, 20'h80000)), '0);
    write_reg(ffra_pkg::CFG_HEAP_LIMIT,
              (ffra_pkg::CFG_DATA_W)'(base_addr + $urandom_range(16'h400, 16'h6000)));
    feed(100, MIX_GENERAL);

    // Limit zero: nothing can grow, only the list serves
    setup(21'd0, 21'd0);
    feed(60, MIX_GENERAL);

    // Small sizes with no idling on either side: fragment the list until full
    setup(21'd0, 21'h100000);
    @(negedge clk);
    steady <= 1'b1;
    feed(150, MIX_CRUMBS);
    steady <= 1'b0;

    // Anything the registers allow
    setup((ffra_pkg::CFG_DATA_W)'($urandom_range(0, 20'hFFFFF)),
          (ffra_pkg::CFG_DATA_W)'($urandom_range(0, 21'h1FFFFF)));
    feed(110, MIX_GENERAL);

    // Let any late or spurious result show up before judging
    repeat (TAIL_CYCLES) @(negedge clk);
    if (faults == 0 && grants_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ffra_pkg.sv
design/ffra_if.sv
design/first_fit_region_allocator_core.sv
design/ffra_checker.sv
bench/tb_top.sv
